>>> src/rskf_pkg.sv
// ----------------------------------------------------------------------------
// rskf_pkg
// shared types and codes for the robust scalar kalman filter core
// ----------------------------------------------------------------------------
package rskf_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PROCESS_NOISE     = 3'd0;
    localparam logic [2:0] CFG_MEASUREMENT_NOISE = 3'd1;
    localparam logic [2:0] CFG_INITIAL_ESTIMATE  = 3'd2;
    localparam logic [2:0] CFG_INITIAL_VARIANCE  = 3'd3;
    localparam logic [2:0] CFG_WEIGHT_MODE       = 3'd4;
    localparam logic [2:0] CFG_HUBER_THRESHOLD   = 3'd5;
    localparam logic [2:0] CFG_STUDENT_DOF       = 3'd6;

    // weight modes
    localparam logic [1:0] MODE_GAUSS   = 2'd0;
    localparam logic [1:0] MODE_HUBER   = 2'd1;
    localparam logic [1:0] MODE_STUDENT = 2'd2;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    // request to the shared divide / square root unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } t_iter_req;

endpackage

>>> src/rskf_iter.sv
// ----------------------------------------------------------------------------
// rskf_iter
// shared restoring divider and digit-by-digit square root, one bit a cycle
// ----------------------------------------------------------------------------
module rskf_iter
    import rskf_pkg::*;
#(
    parameter int NW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_iter_req     i_req,
    input  logic [NW-1:0] i_num,
    input  logic [63:0]   i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int RW = 66;
    localparam int CW = $clog2(NW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_sqrt;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rem;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [63:0]   r_den;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;
    logic [CW-1:0] last;

    always_comb begin
        if (r_sqrt) begin
            rem_sh = {r_rem[RW-3:0], r_num[NW-1:NW-2]};
            trial  = RW'({r_quo, 2'b01});
            last   = CW'(NW / 2 - 1);
        end else begin
            rem_sh = {r_rem[RW-2:0], r_num[NW-1]};
            trial  = {2'b00, r_den};
            last   = CW'(NW - 1);
        end
        ge     = (rem_sh >= trial);
        n_busy = r_busy;
        n_done = 1'b0;
        if (r_busy && r_cnt == last) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
        if (i_req.start) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.is_sqrt;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - trial) : rem_sh;
            r_quo <= {r_quo[NW-2:0], ge};
            r_num <= r_sqrt ? {r_num[NW-3:0], 2'b00} : {r_num[NW-2:0], 1'b0};
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> src/robust_scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// robust_scalar_kalman_filter_core
// scalar random-walk kalman filter with huber / student-t gain reweighting
// ----------------------------------------------------------------------------
// channel | direction | handshake             | words
// in      | input     | i_in_valid/o_in_stall | i_measurement, i_start_req
// out     | output    | o_out_valid/i_out_stall | o_estimate, o_weight, o_variance
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// the divider word NW is 32 + FRAC_BITS rounded up to even. huber with
// clipping adds one more division, and student-t adds a square, a sum and
// one more division (skipped if the sum is zero). the input reopens in the
// same cycle that the result is loaded into the output register. the shared
// divide / square root unit produces one bit a cycle.
// synchronous active-low reset restores register defaults and the state.
// input is stalled while a word is in work; a stalled result waits in the
// output register and the next word may be accepted meanwhile.
// ----------------------------------------------------------------------------
module robust_scalar_kalman_filter_core
    import rskf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_measurement,
    input  logic        i_start_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_estimate,
    output logic [16:0] o_weight,
    output logic [30:0] o_variance,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int NW  = 32 + F + (F % 2);   // divider / root word
    localparam int HW  = NW / 2;             // root width
    localparam int WW  = F + 1;              // weight, gain, reweighted gain
    localparam int WSR = (F >= 16) ? F - 16 : 0;
    localparam int WSL = (F >= 16) ? 0 : 16 - F;
    localparam logic [WW-1:0] WMAX  = {WW{1'b1}};
    localparam logic [WW-1:0] ONE_W = WW'(1) << F;
    localparam logic [31:0]   ONE32 = 32'd1 << F;
    localparam logic signed [67:0] SMAX = 68'sh7FFF_FFFF;
    localparam logic signed [67:0] SMIN = -68'sh8000_0000;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRED  = 4'd1;
    localparam logic [3:0] S_INNOV = 4'd2;
    localparam logic [3:0] S_KDIV  = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_ADIV  = 4'd5;
    localparam logic [3:0] S_WSEL  = 4'd6;
    localparam logic [3:0] S_SQMUL = 4'd7;
    localparam logic [3:0] S_DEN   = 4'd8;
    localparam logic [3:0] S_WDIV  = 4'd9;
    localparam logic [3:0] S_KMUL  = 4'd10;
    localparam logic [3:0] S_XMUL  = 4'd11;
    localparam logic [3:0] S_XUPD  = 4'd12;
    localparam logic [3:0] S_PUPD  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    // configuration registers
    logic [30:0] r_q, r_r, r_p0, r_c, r_nu;
    logic [31:0] r_x0;
    logic [1:0]  r_mode;

    // filter state and working registers
    logic [3:0]         r_state, n_state;
    logic               r_issued;
    logic signed [31:0] r_x, r_xn, r_y;
    logic [31:0]        r_z;
    logic [30:0]        r_p, r_pn, r_pp, r_s;
    logic [WW-1:0]      r_k, r_w, r_kr;
    logic [HW-1:0]      r_sq;
    logic [31:0]        r_a;
    logic [63:0]        r_den;
    logic signed [67:0] r_prod;
    logic               r_out_valid;
    logic [31:0]        r_out_x;
    logic [16:0]        r_out_w;
    logic [30:0]        r_out_p;

    // shared unit
    t_iter_req     iter_req;
    logic [NW-1:0] iter_num;
    logic [63:0]   iter_den;
    logic          iter_done;
    logic [NW-1:0] iter_quo;

    logic               in_acc;
    logic               slot_free;
    logic               wait_state;
    logic               skip_div;
    logic [31:0]        pp_sum, s_sum;
    logic signed [32:0] diff;
    logic [31:0]        ay;
    logic [31:0]        nu_one;
    logic [63:0]        r2;
    logic [63:0]        den_sum;
    logic signed [33:0] m_a, m_b, omk;
    logic signed [67:0] m_p;
    logic [WW-1:0]      kr_c;
    logic signed [67:0] xs, ps;
    logic [31:0]        w32, wsh;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign slot_free   = !r_out_valid || !i_out_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q    <= 31'd6554;
            r_r    <= 31'd65536;
            r_x0   <= 32'd0;
            r_p0   <= 31'd65536;
            r_mode <= MODE_GAUSS;
            r_c    <= 31'd88146;
            r_nu   <= 31'd262144;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PROCESS_NOISE:     r_q    <= i_cfg_data[30:0];
                CFG_MEASUREMENT_NOISE: r_r    <= i_cfg_data[30:0];
                CFG_INITIAL_ESTIMATE:  r_x0   <= i_cfg_data;
                CFG_INITIAL_VARIANCE:  r_p0   <= i_cfg_data[30:0];
                CFG_WEIGHT_MODE:       r_mode <= i_cfg_data[1:0];
                CFG_HUBER_THRESHOLD:   r_c    <= i_cfg_data[30:0];
                CFG_STUDENT_DOF:       r_nu   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // datapath helpers
    always_comb begin
        pp_sum  = {1'b0, r_p} + {1'b0, r_q};
        s_sum   = {1'b0, r_pp} + {1'b0, r_r};
        diff    = {r_z[31], r_z} - {r_x[31], r_x};
        ay      = r_y[31] ? (~r_y + 32'd1) : r_y;
        nu_one  = {1'b0, r_nu} + ONE32;
        r2      = 64'(r_prod >>> F);
        den_sum = r2 + 64'(r_nu);
        kr_c    = r_prod[F +: WW];
        omk     = (34'sd1 <<< F) - $signed({{(34-WW){1'b0}}, r_kr});
        // signed sum so the product shift rounds toward minus infinity
        xs      = $signed({{36{r_x[31]}}, r_x}) + (r_prod >>> F);
        ps      = r_prod >>> F;
        w32     = 32'(r_w);
        wsh     = (w32 >> WSR) << WSL;
    end

    // single shared multiplier, operands picked by the sequencer
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_SQMUL: begin
                m_a = {2'b00, r_a};
                m_b = {2'b00, r_a};
            end
            S_KMUL: begin
                m_a = {{(34-WW){1'b0}}, r_w};
                m_b = {{(34-WW){1'b0}}, r_k};
            end
            S_XMUL: begin
                m_a = {{(34-WW){1'b0}}, kr_c};
                m_b = {{2{r_y[31]}}, r_y};
            end
            S_XUPD: begin
                m_a = omk;
                m_b = {3'b000, r_pp};
            end
            default: ;
        endcase
    end
    assign m_p = m_a * m_b;

    // divide / root operand selection; a zero divisor skips the unit
    always_comb begin
        iter_num = '0;
        iter_den = '0;
        skip_div = 1'b0;
        iter_req.is_sqrt = (r_state == S_SQRT);
        case (r_state)
            S_KDIV: begin
                iter_num = NW'(r_pp) << F;
                iter_den = 64'(r_s);
                skip_div = (r_s == '0);
            end
            S_SQRT: begin
                iter_num = NW'(r_s) << F;
            end
            S_ADIV: begin
                iter_num = NW'(ay) << F;
                iter_den = 64'(r_sq);
                skip_div = (r_sq == '0);
            end
            S_WDIV: begin
                if (r_mode == MODE_HUBER) begin
                    iter_num = NW'(r_c) << F;
                    iter_den = 64'(r_a);
                end else begin
                    iter_num = NW'(nu_one) << F;
                    iter_den = r_den;
                end
            end
            default: ;
        endcase
        wait_state = (r_state == S_KDIV) || (r_state == S_SQRT) ||
                     (r_state == S_ADIV) || (r_state == S_WDIV);
        iter_req.start = wait_state && !r_issued && !skip_div;
    end

    rskf_iter #(
        .NW (NW)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .i_num   (iter_num),
        .i_den   (iter_den),
        .o_done  (iter_done),
        .o_quo   (iter_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_PRED;
            S_PRED:  n_state = S_INNOV;
            S_INNOV: n_state = S_KDIV;
            S_KDIV:  if (skip_div || iter_done) n_state = S_SQRT;
            S_SQRT:  if (iter_done) n_state = S_ADIV;
            S_ADIV:  if (skip_div || iter_done) n_state = S_WSEL;
            S_WSEL: begin
                unique case (r_mode)
                    MODE_HUBER:   n_state = (r_a > {1'b0, r_c}) ? S_WDIV : S_KMUL;
                    MODE_STUDENT: n_state = S_SQMUL;
                    default:      n_state = S_KMUL;
                endcase
            end
            S_SQMUL: n_state = S_DEN;
            S_DEN:   n_state = (den_sum == '0) ? S_KMUL : S_WDIV;
            S_WDIV:  if (iter_done) n_state = S_KMUL;
            S_KMUL:  n_state = S_XMUL;
            S_XMUL:  n_state = S_XUPD;
            S_XUPD:  n_state = S_PUPD;
            S_PUPD:  n_state = S_DONE;
            S_DONE:  if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_p         <= 31'd65536;
        end else begin
            r_state <= n_state;
            if (iter_req.start) begin
                r_issued <= 1'b1;
            end else if (iter_done) begin
                r_issued <= 1'b0;
            end
            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
                r_x         <= r_xn;
                r_p         <= r_pn;
            end else begin
                if (!i_out_stall) r_out_valid <= 1'b0;
                if (in_acc && i_start_req) begin
                    // sequence start reloads the state before this step
                    r_x <= r_x0;
                    r_p <= r_p0;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE:  if (in_acc) r_z <= i_measurement;
            S_PRED:  r_pp <= pp_sum[31] ? MAX31 : pp_sum[30:0];
            S_INNOV: begin
                r_s <= s_sum[31] ? MAX31 : s_sum[30:0];
                if (diff[32] != diff[31]) begin
                    r_y <= diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_y <= diff[31:0];
                end
            end
            S_KDIV: begin
                if (skip_div)       r_k <= '0;
                else if (iter_done) r_k <= iter_quo[WW-1:0];
            end
            S_SQRT:  if (iter_done) r_sq <= iter_quo[HW-1:0];
            S_ADIV: begin
                if (skip_div) begin
                    r_a <= '0;
                end else if (iter_done) begin
                    r_a <= (|iter_quo[NW-1:32]) ? 32'hFFFF_FFFF : iter_quo[31:0];
                end
            end
            S_WSEL:  r_w <= ONE_W;
            S_SQMUL: r_prod <= m_p;
            S_DEN: begin
                r_den <= den_sum;
                if (den_sum == '0) r_w <= WMAX;
            end
            S_WDIV: begin
                if (iter_done) begin
                    r_w <= (iter_quo > NW'(WMAX)) ? WMAX : iter_quo[WW-1:0];
                end
            end
            S_KMUL:  r_prod <= m_p;
            S_XMUL: begin
                r_kr   <= kr_c;
                r_prod <= m_p;
            end
            S_XUPD: begin
                if (xs > SMAX)      r_xn <= 32'sh7FFF_FFFF;
                else if (xs < SMIN) r_xn <= 32'sh8000_0000;
                else                r_xn <= xs[31:0];
                r_prod <= m_p;
            end
            S_PUPD: begin
                // a gain above one drives the variance negative: clamp at zero
                if (ps < 0)         r_pn <= '0;
                else if (ps > SMAX) r_pn <= MAX31;
                else                r_pn <= ps[30:0];
            end
            S_DONE: begin
                if (slot_free) begin
                    r_out_x <= r_xn;
                    r_out_w <= (|wsh[31:17]) ? 17'h1FFFF : wsh[16:0];
                    r_out_p <= r_pn;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_out_x;
    assign o_weight    = r_out_w;
    assign o_variance  = r_out_p;

    // checks
    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_PRED))
        else $error("accepted word did not start the sequencer");

    a_done_in_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_done |-> (r_state == S_KDIV || r_state == S_SQRT ||
                       r_state == S_ADIV || r_state == S_WDIV))
        else $error("shared unit finished outside a wait state");

    a_hold_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result overwrote a stalled word");

    a_no_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (iter_req.start && r_issued) |-> 1'b0)
        else $error("shared unit started twice");

endmodule
